FILE: hw/rtl/fia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_pkg
// Shared widths, event codes and divider handshake types for the frame
// interval averager.
// ----------------------------------------------------------------------------
package fia_pkg;

    localparam int WINDOW_DEPTH = 64;

    localparam int FUNC_W   = 2;
    localparam int TS_W     = 64;
    localparam int SAMPLE_W = 32;
    localparam int RATE_W   = 32;
    localparam int TPS_W    = 32;

    localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(10000000);

    // event codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hw/rtl/fia_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_if
// Valid/ready channels: timer events in, averaged results out.
// ----------------------------------------------------------------------------
interface fia_evt_if;
    import fia_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, func, timestamp, input ready);
    modport sink   (input valid, func, timestamp, output ready);
endinterface

interface fia_res_if;
    import fia_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] avg_interval;
    logic [RATE_W-1:0]   frame_rate;
    logic                running;

    modport source (output valid, avg_interval, frame_rate, running, input ready);
    modport sink   (input valid, avg_interval, frame_rate, running, output ready);
endinterface

FILE: hw/rtl/fia_sample_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_sample_ram
// Interval sample ring storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fia_sample_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [fia_pkg::PTR_W-1:0]    waddr,
    input  logic [fia_pkg::SAMPLE_W-1:0] wdata,
    input  logic [fia_pkg::PTR_W-1:0]    raddr,
    output logic [fia_pkg::SAMPLE_W-1:0] rdata
);
    import fia_pkg::*;

    logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/fia_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_divider
// Restoring divider, one quotient bit per cycle: window sum / sample count.
// ----------------------------------------------------------------------------
module fia_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  fia_pkg::div_req_t req,
    output fia_pkg::div_rsp_t rsp
);
    import fia_pkg::*;

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic              qbit;

    // shift next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[SUM_W-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qbit      = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dvs_reg});
                qbit     = 1'b1;
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            quo_next  = {quo_reg[SUM_W-2:0], qbit};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // quotient is an average of 32-bit samples, so the low bits hold it all
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[SAMPLE_W-1:0];

endmodule

FILE: hw/rtl/frame_interval_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_interval_averager
// Moving-average frame timer with frames-per-second counter.
// ----------------------------------------------------------------------------
// Each event transaction carries a func code (frame tick, start, stop) and a
// 64-bit free-running counter timestamp, and yields exactly one result
// transaction with the current average interval, frame rate and run flag.
// A frame tick while running goes from acceptance to result through S_DIFF
// and S_TEST (64-bit interval, outlier and rate-window arithmetic), S_DROP
// and S_ADD (one ring update), S_DIV_START and S_DIV_WAIT (the bit-serial
// divider that produces one quotient bit per cycle for window_sum /
// sample_count), then S_OUT. Start, stop, stopped ticks and the unused code
// go straight to S_OUT. The block holds one event at a time; a result sits in
// an output register, so the next event can be accepted while the previous
// result waits. The user must write ticks_per_second through cfg_wr_en/
// cfg_wr_data only while idle (the block does not enforce this); it resets to
// 10,000,000. The sample ring is not cleared at reset: only written slots are used.
// ----------------------------------------------------------------------------
module frame_interval_averager (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [fia_pkg::TPS_W-1:0] cfg_wr_data,
    fia_evt_if.sink                   evt_ch,
    fia_res_if.source                 res_ch
);
    import fia_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_TEST,
        S_DROP,
        S_ADD,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [TPS_W-1:0]    tps_reg, tps_next;
    logic [TS_W-1:0]     last_ts_reg, last_ts_next;
    logic [TS_W-1:0]     te_reg, te_next;
    logic [TS_W-1:0]     diff_reg, diff_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                store_reg, store_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] avg_reg, avg_next;
    logic [RATE_W-1:0]   frames_reg, frames_next;
    logic [TS_W-1:0]     acc_reg, acc_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic                stopped_reg, stopped_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_avg_reg, out_avg_next;
    logic [RATE_W-1:0]   out_rate_reg, out_rate_next;
    logic                out_running_reg, out_running_next;

    logic                evt_accept;
    logic                ring_full;
    logic [TS_W:0]       acc_sum;
    logic [TS_W-1:0]     avg_ext;
    logic                ram_we;
    logic [SAMPLE_W-1:0] ram_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign evt_ch.ready = (state_reg == S_IDLE);
    assign evt_accept   = evt_ch.valid && evt_ch.ready;
    assign ring_full    = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign avg_ext      = {{(TS_W-SAMPLE_W){1'b0}}, avg_reg};
    // saturating accumulator add: carry out means pin to all ones
    assign acc_sum      = {1'b0, acc_reg} + {1'b0, te_reg};
    assign ram_we       = (state_reg == S_ADD) && store_reg;

    assign div_req.start    = (state_reg == S_DIV_START) && (count_reg != '0);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = count_reg;

    always_comb
    begin
        state_next       = state_reg;
        tps_next         = tps_reg;
        last_ts_next     = last_ts_reg;
        te_next          = te_reg;
        diff_next        = diff_reg;
        sample_next      = sample_reg;
        store_next       = store_reg;
        ptr_next         = ptr_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        avg_next         = avg_reg;
        frames_next      = frames_reg;
        acc_next         = acc_reg;
        rate_next        = rate_reg;
        stopped_next     = stopped_reg;
        out_valid_next   = out_valid_reg;
        out_avg_next     = out_avg_reg;
        out_rate_next    = out_rate_reg;
        out_running_next = out_running_reg;

        // config must be written only while idle; the block does not enforce it
        if (cfg_wr_en)
        begin
            tps_next = cfg_wr_data;
        end

        if (out_valid_reg && res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_accept)
                begin
                    state_next = S_OUT;
                    case (evt_ch.func)
                        FUNC_TICK:
                        begin
                            if (stopped_reg)
                            begin
                                avg_next = '0;
                            end
                            else
                            begin
                                te_next      = evt_ch.timestamp - last_ts_reg;
                                last_ts_next = evt_ch.timestamp;
                                state_next   = S_DIFF;
                            end
                        end
                        FUNC_START:
                        begin
                            if (stopped_reg)
                            begin
                                last_ts_next = evt_ch.timestamp;
                                stopped_next = 1'b0;
                            end
                        end
                        FUNC_STOP:
                        begin
                            stopped_next = 1'b1;
                        end
                        default:
                        begin
                            // unused code: report current outputs
                        end
                    endcase
                end
            end
            S_DIFF:
            begin
                // |te - avg|, both differences formed, one picked
                diff_next = (te_reg >= avg_ext) ? (te_reg - avg_ext) : (avg_ext - te_reg);
                if (frames_reg != '1)
                begin
                    frames_next = frames_reg + RATE_W'(1);
                end
                acc_next   = acc_sum[TS_W] ? '1 : acc_sum[TS_W-1:0];
                state_next = S_TEST;
            end
            S_TEST:
            begin
                store_next  = (diff_reg < {{(TS_W-TPS_W){1'b0}}, tps_reg});
                sample_next = (|te_reg[TS_W-1:SAMPLE_W]) ? '1 : te_reg[SAMPLE_W-1:0];
                if (acc_reg > {{(TS_W-TPS_W){1'b0}}, tps_reg})
                begin
                    rate_next   = frames_reg;
                    frames_next = '0;
                    acc_next    = '0;
                end
                state_next = S_DROP;
            end
            S_DROP:
            begin
                // ram_rdata holds the slot at ptr_reg, read during S_TEST
                if (store_reg && ring_full)
                begin
                    sum_next = sum_reg - {{(SUM_W-SAMPLE_W){1'b0}}, ram_rdata};
                end
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (store_reg)
                begin
                    sum_next = sum_reg + {{(SUM_W-SAMPLE_W){1'b0}}, sample_reg};
                    if (!ring_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (ptr_reg == PTR_W'(WINDOW_DEPTH - 1))
                    begin
                        ptr_next = '0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                if (count_reg == '0)
                begin
                    avg_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || res_ch.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_avg_next     = avg_reg;
                    out_rate_next    = rate_reg;
                    out_running_next = !stopped_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tps_reg         <= TPS_RESET;
            last_ts_reg     <= '0;
            te_reg          <= '0;
            diff_reg        <= '0;
            sample_reg      <= '0;
            store_reg       <= 1'b0;
            ptr_reg         <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            avg_reg         <= '0;
            frames_reg      <= '0;
            acc_reg         <= '0;
            rate_reg        <= '0;
            stopped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_avg_reg     <= '0;
            out_rate_reg    <= '0;
            out_running_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tps_reg         <= tps_next;
            last_ts_reg     <= last_ts_next;
            te_reg          <= te_next;
            diff_reg        <= diff_next;
            sample_reg      <= sample_next;
            store_reg       <= store_next;
            ptr_reg         <= ptr_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            avg_reg         <= avg_next;
            frames_reg      <= frames_next;
            acc_reg         <= acc_next;
            rate_reg        <= rate_next;
            stopped_reg     <= stopped_next;
            out_valid_reg   <= out_valid_next;
            out_avg_reg     <= out_avg_next;
            out_rate_reg    <= out_rate_next;
            out_running_reg <= out_running_next;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.avg_interval = out_avg_reg;
    assign res_ch.frame_rate   = out_rate_reg;
    assign res_ch.running      = out_running_reg;

    // sample ring: read slot follows the write pointer continuously
    fia_sample_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (sample_reg),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // serial divider for the window average
    fia_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

FILE: hw/rtl/fia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_props
// Port-level checks for the frame interval averager, bound to the top.
// ----------------------------------------------------------------------------
module fia_props (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         evt_valid,
    input logic                         evt_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [fia_pkg::SAMPLE_W-1:0] res_avg_interval,
    input logic [fia_pkg::RATE_W-1:0]   res_frame_rate,
    input logic                         res_running
);
    import fia_pkg::*;

    logic       evt_acc;
    logic       res_acc;
    logic [1:0] pending_reg, pending_next;

    assign evt_acc = evt_valid && evt_ready;
    assign res_acc = res_valid && res_ready;

    // transactions in flight: accepted events not yet answered
    always_comb
    begin
        pending_next = pending_reg + {1'b0, evt_acc} - {1'b0, res_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // one event at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc |=> !evt_ready)
        else $error("event accepted while previous one still in work");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_avg_interval)
            && $stable(res_frame_rate) && $stable(res_running))
        else $error("stalled result changed");

    a_no_spurious_res: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc |-> pending_reg != 2'd0)
        else $error("result without an event");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two transactions outstanding");

endmodule

bind frame_interval_averager fia_props u_fia_props (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt_valid        (evt_ch.valid),
    .evt_ready        (evt_ch.ready),
    .res_valid        (res_ch.valid),
    .res_ready        (res_ch.ready),
    .res_avg_interval (res_ch.avg_interval),
    .res_frame_rate   (res_ch.frame_rate),
    .res_running      (res_ch.running)
);

FILE: tb/sv/fia_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fia_checker
// Scoreboard for the frame interval averager. Tracks the timer state on
// every accepted event transaction and compares each result transaction,
// in order, against the report that the tracked state gives.
// ----------------------------------------------------------------------------
module fia_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [fia_pkg::TPS_W-1:0]    cfg_wr_data,
    input  logic                         evt_valid,
    input  logic                         evt_ready,
    input  logic [fia_pkg::FUNC_W-1:0]   evt_func,
    input  logic [fia_pkg::TS_W-1:0]     evt_timestamp,
    input  logic                         res_valid,
    input  logic                         res_ready,
    input  logic [fia_pkg::SAMPLE_W-1:0] res_avg_interval,
    input  logic [fia_pkg::RATE_W-1:0]   res_frame_rate,
    input  logic                         res_running,
    output int                           fail_count,
    output int                           results_owed
);
    import fia_pkg::*;

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] avg_interval;
        logic [RATE_W-1:0]   frame_rate;
        logic                running;
    } timer_report_t;

    timer_report_t       owed_reports[$];

    // tracked timer state
    logic [TPS_W-1:0]    tps;
    logic [SAMPLE_W-1:0] interval_ring [WINDOW_DEPTH];
    logic [PTR_W-1:0]    ring_slot;
    logic [CNT_W-1:0]    ring_fill;
    logic [SUM_W-1:0]    ring_total;
    logic [TS_W-1:0]     prev_stamp;
    logic [SAMPLE_W-1:0] mean_interval;
    logic [RATE_W-1:0]   frames_open;
    logic [TS_W-1:0]     open_span;
    logic [RATE_W-1:0]   last_rate;
    logic                halted;

    function automatic timer_report_t advance_timer(input logic [FUNC_W-1:0] func,
                                                    input logic [TS_W-1:0]   stamp);
        logic [TS_W-1:0]     span;
        logic [TS_W-1:0]     gap;
        logic [SAMPLE_W-1:0] kept;
        timer_report_t       rep;
        case (func)
            FUNC_TICK:
            begin
                if (halted)
                begin
                    mean_interval = '0;
                end
                else
                begin
                    span       = stamp - prev_stamp;
                    prev_stamp = stamp;
                    gap = (span >= TS_W'(mean_interval)) ? span - TS_W'(mean_interval)
                                                         : TS_W'(mean_interval) - span;
                    if (gap < TS_W'(tps))
                    begin
                        kept = (span > TS_W'({SAMPLE_W{1'b1}})) ? '1 : span[SAMPLE_W-1:0];
                        if (ring_fill == CNT_W'(WINDOW_DEPTH))
                            ring_total = ring_total - SUM_W'(interval_ring[ring_slot]);
                        else
                            ring_fill = ring_fill + 1'b1;
                        interval_ring[ring_slot] = kept;
                        ring_total = ring_total + SUM_W'(kept);
                        ring_slot  = (ring_slot == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                            : ring_slot + 1'b1;
                    end
                    if (frames_open != '1)
                        frames_open = frames_open + 1'b1;
                    // saturating add: ~span is the headroom left below all ones
                    if (open_span > ~span)
                        open_span = '1;
                    else
                        open_span = open_span + span;
                    if (open_span > TS_W'(tps))
                    begin
                        last_rate   = frames_open;
                        frames_open = '0;
                        open_span   = '0;
                    end
                    mean_interval = (ring_fill != '0)
                                  ? SAMPLE_W'(ring_total / SUM_W'(ring_fill)) : '0;
                end
            end
            FUNC_START:
            begin
                if (halted)
                begin
                    prev_stamp = stamp;
                    halted     = 1'b0;
                end
            end
            FUNC_STOP:
            begin
                halted = 1'b1;
            end
            default:
            begin
            end
        endcase
        rep.avg_interval = mean_interval;
        rep.frame_rate   = last_rate;
        rep.running      = !halted;
        return rep;
    endfunction

    task automatic check_report(input timer_report_t seen);
        timer_report_t want;
        if (owed_reports.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display("%t: result with nothing outstanding: avg %0d rate %0d running %0b",
                         $realtime, seen.avg_interval, seen.frame_rate, seen.running);
            return;
        end
        want = owed_reports.pop_front();
        if (seen.avg_interval !== want.avg_interval || seen.frame_rate !== want.frame_rate
            || seen.running !== want.running)
        begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
                $display("%t: result mismatch: avg %0d/%0d rate %0d/%0d running %0b/%0b (exp/act)",
                         $realtime, want.avg_interval, seen.avg_interval,
                         want.frame_rate, seen.frame_rate, want.running, seen.running);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reports.delete();
            tps           = TPS_RESET;
            ring_slot     = '0;
            ring_fill     = '0;
            ring_total    = '0;
            prev_stamp    = '0;
            mean_interval = '0;
            frames_open   = '0;
            open_span     = '0;
            last_rate     = '0;
            halted        = 1'b0;
            fail_count    = 0;
            results_owed  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                tps = cfg_wr_data;
            // a result leaving now always belongs to an earlier event
            if (res_valid && res_ready)
                check_report({res_avg_interval, res_frame_rate, res_running});
            if (evt_valid && evt_ready)
                owed_reports.push_back(advance_timer(evt_func, evt_timestamp));
            results_owed = owed_reports.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the frame interval averager. A directed run of
// edge cases is followed by phases of random frame streams, each under its
// own ticks_per_second and one of four patterns of sender gaps and receiver
// stalls. Checking is done by fia_checker, which reports a failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import fia_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 204;
    localparam int QUIET_LIMIT = 4000;  // cycles with no transaction at all
    localparam int SETTLE      = 100;   // tail wait before the verdict

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [TPS_W-1:0] cfg_wr_data;

    int fail_count;
    int results_owed;
    int idle_pct;       // sender: chance in 100 of an empty cycle before a transaction
    int stall_pct;      // receiver: chance in 100 of ready low in a cycle
    int quiet_cycles;

    // stream shaping for the random phases
    logic [TS_W-1:0]  stamp;     // free-running counter as the sender sees it
    logic [TS_W-1:0]  frame_iv;  // nominal frame interval in counter ticks
    logic [TS_W-1:0]  jit;       // jitter half-width around frame_iv
    logic [TPS_W-1:0] tps_now;

    fia_evt_if evt_ch ();
    fia_res_if res_ch ();

    frame_interval_averager dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .evt_ch      (evt_ch),
        .res_ch      (res_ch)
    );

    fia_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .evt_valid        (evt_ch.valid),
        .evt_ready        (evt_ch.ready),
        .evt_func         (evt_ch.func),
        .evt_timestamp    (evt_ch.timestamp),
        .res_valid        (res_ch.valid),
        .res_ready        (res_ch.ready),
        .res_avg_interval (res_ch.avg_interval),
        .res_frame_rate   (res_ch.frame_rate),
        .res_running      (res_ch.running),
        .fail_count       (fail_count),
        .results_owed     (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver back-pressure: ready is redrawn every cycle.
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any transaction on either channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("frame_interval_averager verification failed");
                $finish;
            end
        end
    end

    // One event transaction. Called and returning at a rising edge. Ready is
    // looked at on the falling edge, where it has settled for the next rise.
    task automatic send_event(input logic [FUNC_W-1:0] func, input logic [TS_W-1:0] ts);
        while ($urandom_range(99) < idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid     <= 1'b1;
        evt_ch.func      <= func;
        evt_ch.timestamp <= ts;
        @(negedge clk);
        while (!evt_ch.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold the sender off until every owed result has been taken.
    task automatic drain_results();
        evt_ch.valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_tps(input logic [TPS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 84; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 84; end
            default: begin idle_pct = 14; stall_pct = 14; end
        endcase
    endtask

    // Mostly a steady frame stream with jitter; the rest are threshold
    // probes, wild stamps, stops, starts, the unused code and stamps
    // that repeat or run backwards (interval zero or wrapped).
    task automatic send_random_event();
        int pick;
        pick = $urandom_range(99);
        if (pick < 78)
        begin
            stamp = stamp + frame_iv - jit + TS_W'($urandom_range(0, 32'(2 * jit)));
            send_event(FUNC_TICK, stamp);
        end
        else if (pick < 82)
        begin
            // lands within a couple of ticks of the outlier threshold
            stamp = stamp + frame_iv + TS_W'(tps_now) - 2 + TS_W'($urandom_range(0, 4));
            send_event(FUNC_TICK, stamp);
        end
        else if (pick < 85)
        begin
            stamp = {$urandom, $urandom};
            send_event(FUNC_TICK, stamp);
        end
        else if (pick < 91)
        begin
            stamp = stamp + TS_W'($urandom_range(0, 32'(frame_iv)));
            send_event(FUNC_STOP, stamp);
        end
        else if (pick < 97)
        begin
            stamp = stamp + TS_W'($urandom_range(0, 32'(4 * frame_iv)));
            send_event(FUNC_START, stamp);
        end
        else if (pick < 99)
        begin
            send_event(FUNC_UNUSED, {$urandom, $urandom});
        end
        else
        begin
            stamp = stamp - TS_W'($urandom_range(0, 3));
            send_event(FUNC_TICK, stamp);
        end
    endtask

    initial
    begin
        logic [TPS_W-1:0] tps_plan [NUM_PHASES];

        rst_n            = 1'b0;
        evt_ch.valid     <= 1'b0;
        evt_ch.func      <= FUNC_TICK;
        evt_ch.timestamp <= '0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        set_idling(0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part, reset ticks_per_second ----------------
        send_event(FUNC_TICK, 64'd0);            // zero interval against the reset stamp
        send_event(FUNC_TICK, 64'd166_666);
        send_event(FUNC_UNUSED, '1);             // unused code: outputs only
        send_event(FUNC_START, 64'd5);           // start while running is ignored
        send_event(FUNC_STOP, 64'd0);            // average must hold until next tick
        send_event(FUNC_TICK, 64'd123);          // tick while stopped clears the average
        send_event(FUNC_STOP, 64'd7);
        stamp = 64'hFFFF_FFFF_FFFF_FF00;
        send_event(FUNC_START, stamp);           // re-arm just below the wrap
        stamp = 64'h0000_0000_0000_1000;
        send_event(FUNC_TICK, stamp);            // interval across the counter wrap
        stamp = stamp + 64'd20_000_000;
        send_event(FUNC_TICK, stamp);            // outlier, also closes the rate window
        send_event(FUNC_TICK, stamp);            // zero interval
        stamp = stamp - 1;
        send_event(FUNC_TICK, stamp);            // all-ones interval, accumulator reaches all ones
        stamp = stamp + 64'h0000_0100_0000_0000;
        send_event(FUNC_TICK, stamp);

        // widest threshold: first window closes only once strictly above it
        drain_results();
        write_tps('1);
        repeat (3)
        begin
            stamp = stamp + 64'h0000_0000_FFFF_FFFF;
            send_event(FUNC_TICK, stamp);
        end
        stamp = stamp + 64'h0000_0001_2000_0000;
        send_event(FUNC_TICK, stamp);            // over 32 bits but kept: stored saturated
        stamp = stamp + 64'h0000_0002_0000_0000;
        send_event(FUNC_TICK, stamp);            // rejected as an outlier

        // ---------------- random phases ----------------
        // Zero threshold rejects every sample; one keeps only exact matches.
        tps_plan[0] = '1;
        tps_plan[1] = 32'd1;
        tps_plan[2] = TPS_RESET;
        tps_plan[3] = 32'd0;
        tps_plan[4] = $urandom;
        tps_plan[5] = 32'd1000;
        tps_plan[6] = 32'd100_000;
        tps_plan[7] = $urandom_range(1000, 50_000_000);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // every phase starts from an idle block, the sender held off
            drain_results();
            tps_now = tps_plan[p];
            write_tps(tps_now);
            set_idling(p % 4);
            if (tps_now == '0)
                frame_iv = TS_W'($urandom_range(1, 1000));
            else
                frame_iv = TS_W'(tps_now) / TS_W'($urandom_range(24, 240));
            if (frame_iv == '0)
                frame_iv = 1;
            jit   = frame_iv / 4 + 1;
            stamp = {$urandom, $urandom};
            repeat (PHASE_ITEMS)
                send_random_event();
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0 && results_owed == 0)
            $display("frame_interval_averager verification clean");
        else
            $display("frame_interval_averager verification failed");
        $finish;
    end

endmodule
